// File: sv/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types, codes and helpers for the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

  // position in the token
  localparam logic [1:0] POS_START  = 2'd0;
  localparam logic [1:0] POS_SIGN   = 2'd1;
  localparam logic [1:0] POS_LEAD0  = 2'd2;
  localparam logic [1:0] POS_DIGITS = 2'd3;

  // radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_HEX = 2'd1;
  localparam logic [1:0] RADIX_BIN = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TOO_BIG = 2'd1;
  localparam logic [1:0] ERR_BAD     = 2'd2;

  // characters of interest
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_B     = 8'h62;

  localparam int ACC_W  = 16;  // magnitude always stays below 2^16
  localparam int NEXT_W = 21;  // accum * 16 + 15

  // parser state carried between characters
  typedef struct packed {
    logic [1:0]       pos;
    logic             negative;
    logic [1:0]       radix;
    logic [ACC_W-1:0] accum;
    logic             has_digit;
    logic [1:0]       err;
  } state_t;

  localparam state_t STATE_RESET = '{
    pos:       POS_START,
    negative:  1'b0,
    radix:     RADIX_DEC,
    accum:     '0,
    has_digit: 1'b0,
    err:       ERR_NONE
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  // digit decode, 0-9 a-f A-F in any base
  function automatic digit_t digit_value(logic [7:0] c);
    digit_t     d;
    logic [7:0] diff;
    d    = '0;
    diff = '0;
    if (c inside {[8'h30:8'h39]}) begin
      diff = c - 8'h30;
      d.ok = 1'b1;
    end else if (c inside {[8'h61:8'h66]}) begin
      diff = c - 8'h57;
      d.ok = 1'b1;
    end else if (c inside {[8'h41:8'h46]}) begin
      diff = c - 8'h37;
      d.ok = 1'b1;
    end
    d.val = diff[3:0];
    return d;
  endfunction

endpackage

// File: sv/ilp_in_if.sv
// ----------------------------------------------------------------------------
// ilp_in_if
// Character channel: one token character per item.
// ----------------------------------------------------------------------------
interface ilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  logic       narrow;

  modport source (output valid, output ch, output last, output narrow, input ready);
  modport sink (input valid, input ch, input last, input narrow, output ready);
endinterface

// File: sv/ilp_out_if.sv
// ----------------------------------------------------------------------------
// ilp_out_if
// Result channel: parsed value and error code, one item per token.
// ----------------------------------------------------------------------------
interface ilp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic [1:0]         error;

  modport source (output valid, output value, output error, input ready);
  modport sink (input valid, input value, input error, output ready);
endinterface

// File: sv/ilp_step.sv
// ----------------------------------------------------------------------------
// ilp_step
// Next-state and result logic for one character of a token.
// ----------------------------------------------------------------------------
module ilp_step (
  input  ilp_pkg::state_t    state_i,
  input  logic [7:0]         ch_i,
  input  logic               narrow_i,
  output ilp_pkg::state_t    state_o,
  output logic signed [15:0] value_o,
  output logic [1:0]         error_o
);

  ilp_pkg::digit_t                 dig;
  logic [ilp_pkg::NEXT_W-1:0]      acc_ext;
  logic [ilp_pkg::NEXT_W-1:0]      scaled;
  logic [ilp_pkg::NEXT_W-1:0]      next_acc;
  logic [16:0]                     bound;
  logic                            too_big;
  ilp_pkg::state_t                 nxt;
  logic [1:0]                      err_f;
  logic [15:0]                     mag;
  logic [15:0]                     v16;

  assign dig     = ilp_pkg::digit_value(ch_i);
  assign acc_ext = {{(ilp_pkg::NEXT_W - ilp_pkg::ACC_W){1'b0}}, state_i.accum};

  // accum * base, base being a power of two or ten
  always_comb begin
    case (state_i.radix)
      ilp_pkg::RADIX_HEX: scaled = acc_ext << 4;
      ilp_pkg::RADIX_BIN: scaled = acc_ext << 1;
      default:            scaled = (acc_ext << 3) + (acc_ext << 1);
    endcase
  end

  assign next_acc = scaled + {{(ilp_pkg::NEXT_W - 4){1'b0}}, dig.val};

  // bound: 2^W positive, 2^(W-1) negative
  always_comb begin
    if (narrow_i) begin
      bound = state_i.negative ? 17'd128 : 17'd256;
    end else begin
      bound = state_i.negative ? 17'd32768 : 17'd65536;
    end
  end

  assign too_big = next_acc >= {{(ilp_pkg::NEXT_W - 17){1'b0}}, bound};

  // token walk
  always_comb begin
    nxt = state_i;
    if (state_i.err == ilp_pkg::ERR_NONE) begin
      if (state_i.pos == ilp_pkg::POS_START && ch_i == ilp_pkg::CH_MINUS) begin
        nxt.negative = 1'b1;
        nxt.pos      = ilp_pkg::POS_SIGN;
      end else if (state_i.pos == ilp_pkg::POS_START || state_i.pos == ilp_pkg::POS_SIGN)
      begin
        if (ch_i == ilp_pkg::CH_ZERO) begin
          nxt.accum     = '0;
          nxt.has_digit = 1'b1;
          nxt.pos       = ilp_pkg::POS_LEAD0;
        end else begin
          nxt.pos = ilp_pkg::POS_DIGITS;
          if (!dig.ok) begin
            nxt.err = ilp_pkg::ERR_BAD;
          end else begin
            nxt.has_digit = 1'b1;
            if (too_big) nxt.err = ilp_pkg::ERR_TOO_BIG;
            else nxt.accum = next_acc[ilp_pkg::ACC_W-1:0];
          end
        end
      end else if (state_i.pos == ilp_pkg::POS_LEAD0 &&
                   (ch_i == ilp_pkg::CH_X || ch_i == ilp_pkg::CH_B)) begin
        nxt.radix     = (ch_i == ilp_pkg::CH_X) ? ilp_pkg::RADIX_HEX : ilp_pkg::RADIX_BIN;
        nxt.accum     = '0;
        nxt.has_digit = 1'b0;
        nxt.pos       = ilp_pkg::POS_DIGITS;
      end else begin
        nxt.pos = ilp_pkg::POS_DIGITS;
        if (!dig.ok) begin
          nxt.err = ilp_pkg::ERR_BAD;
        end else begin
          nxt.has_digit = 1'b1;
          if (too_big) nxt.err = ilp_pkg::ERR_TOO_BIG;
          else nxt.accum = next_acc[ilp_pkg::ACC_W-1:0];
        end
      end
    end
  end

  assign state_o = nxt;

  // final value, valid when this character ends the token
  always_comb begin
    err_f = nxt.err;
    if (err_f == ilp_pkg::ERR_NONE && !nxt.has_digit) err_f = ilp_pkg::ERR_BAD;
    mag = nxt.negative ? (~nxt.accum + 16'd1) : nxt.accum;
    if (err_f != ilp_pkg::ERR_NONE) begin
      v16 = '0;
    end else if (narrow_i) begin
      v16 = {{8{mag[7]}}, mag[7:0]};
    end else begin
      v16 = mag;
    end
  end

  assign value_o = v16;
  assign error_o = err_f;

endmodule

// File: sv/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses a signed decimal, 0x hex or 0b binary literal, one character per
// item, and returns the value and an error code on the final character.
// ----------------------------------------------------------------------------
// the final character is registered, then its result is registered for output
// throughput: one character per cycle, but a final character waits for a result
//   free slot; character and result registers let a new item in while a result waits
// reset: rst_ni clears the token state and both valid flags
module integer_literal_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  ilp_in_if.sink          in_i,
  ilp_out_if.source       out_o
);

  // character register
  logic        in_valid_q;
  logic [7:0]  ch_q;
  logic        last_q;
  logic        narrow_q;

  // token state and result register
  ilp_pkg::state_t    state_q, state_d, step_state;
  logic               out_valid_q;
  logic signed [15:0] value_q;
  logic [1:0]         error_q;
  logic signed [15:0] step_value;
  logic [1:0]         step_error;
  logic               advance;
  logic               in_ready;

  ilp_step u_step (
    .state_i  (state_q),
    .ch_i     (ch_q),
    .narrow_i (narrow_q),
    .state_o  (step_state),
    .value_o  (step_value),
    .error_o  (step_error)
  );

  // the held character moves on unless it ends a token and the result slot is busy
  assign advance  = in_valid_q && (!last_q || !out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      ch_q     <= in_i.ch;
      last_q   <= in_i.last;
      narrow_q <= in_i.narrow;
    end
  end

  // state returns to reset after the final character
  always_comb begin
    state_d = state_q;
    if (advance) state_d = last_q ? ilp_pkg::STATE_RESET : step_state;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ilp_pkg::STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      value_q <= step_value;
      error_q <= step_error;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = value_q;
  assign out_o.error = error_q;

  // an error result always reports zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && error_q != ilp_pkg::ERR_NONE |-> value_q == 16'sd0)
    else $error("error result with nonzero value");

  // no unused error code reaches the output
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> error_q != 2'd3)
    else $error("illegal error code");

  // token state is cleared after its final character
  a_state_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> state_q == ilp_pkg::STATE_RESET)
    else $error("state not cleared after final character");

  // an error sticks for the rest of the token
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !last_q && state_q.err != ilp_pkg::ERR_NONE |=>
      state_q.err == $past(state_q.err))
    else $error("error code changed mid-token");

endmodule
